// ===== rtl/msts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package msts_pkg;

   typedef enum logic [3:0] {
      PH_IDLE        = 4'd0,
      PH_MEM_START   = 4'd1,
      PH_ST_DELAY    = 4'd2,
      PH_ST_WAIT     = 4'd3,
      PH_ST_ACTIVE   = 4'd4,
      PH_HID_DELAY   = 4'd5,
      PH_HID_WAIT    = 4'd6,
      PH_HID_ACTIVE  = 4'd7,
      PH_MEM_TIMEOUT = 4'd8
   } phase_type;

   localparam logic [1:0] KIND_STEP      = 2'd0;
   localparam logic [1:0] KIND_START_MEM = 2'd1;
   localparam logic [1:0] KIND_START_HID = 2'd2;

   localparam logic [1:0] CSR_MEMORY_TIMEOUT = 2'd0;
   localparam logic [1:0] CSR_USB_DELAY      = 2'd1;
   localparam logic [1:0] CSR_STATUS_TIMEOUT = 2'd2;

   localparam logic [15:0] MEMORY_TIMEOUT_RESET = 16'd2000;
   localparam logic [15:0] USB_DELAY_RESET      = 16'd100;
   localparam logic [15:0] STATUS_TIMEOUT_RESET = 16'd2000;

   typedef struct packed {
      logic [15:0] memory_timeout_ms;
      logic [15:0] usb_delay_ms;
      logic [15:0] status_timeout_ms;
   } cfg_type;

   typedef struct packed {
      phase_type   phase;
      logic [31:0] memory_deadline;
      logic [31:0] usb_deadline;
      logic [31:0] transport_deadline;
   } seq_state_type;

   typedef struct packed {
      logic      start_accepted;
      logic      enable_usb;
      logic      fallback_native;
      logic      display_error;
      logic      reset_memory;
      phase_type phase_now;
      logic      memory_busy;
      logic      hid_busy;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/mode_startup_timeout_sequencer_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// a word accepted on req passes through the input register and then the result register to rsp
// throughput: one word per cycle while rsp_ready is high; req_ready drops only while both registers hold unread words
// the phase update and three 32-bit wrap-safe compares sit in one stage between those registers
// reset: synchronous, clears the valid flags of both registers, returns to idle with all deadlines zero
// and loads the default delays into the configuration registers

module mode_startup_timeout_sequencer_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_kind,
   input  wire logic [31:0] req_now_ms,
   input  wire logic        req_memory_complete,
   input  wire logic        req_mode_ok,
   input  wire logic        req_link_active,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_start_accepted,
   output logic             rsp_enable_usb,
   output logic             rsp_fallback_native,
   output logic             rsp_display_error,
   output logic             rsp_reset_memory,
   output logic [3:0]       rsp_phase_now,
   output logic             rsp_memory_busy,
   output logic             rsp_hid_busy,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   logic                     in_valid_ff;
   logic [1:0]               kind_ff;
   logic [31:0]              now_ff;
   logic                     done_ff;
   logic                     mode_ff;
   logic                     link_ff;
   msts_pkg::cfg_type        cfg_ff;
   msts_pkg::seq_state_type  state_ff;
   msts_pkg::seq_state_type  state_in;
   msts_pkg::result_type     rsp_ff;
   msts_pkg::result_type     rsp_in;
   logic                     rsp_valid_ff;
   logic                     out_free;
   logic                     fire;

   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign fire      = in_valid_ff & out_free;
   assign req_ready = ~in_valid_ff | out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         kind_ff <= req_kind;
         now_ff  <= req_now_ms;
         done_ff <= req_memory_complete;
         mode_ff <= req_mode_ok;
         link_ff <= req_link_active;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.memory_timeout_ms <= msts_pkg::MEMORY_TIMEOUT_RESET;
         cfg_ff.usb_delay_ms      <= msts_pkg::USB_DELAY_RESET;
         cfg_ff.status_timeout_ms <= msts_pkg::STATUS_TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            msts_pkg::CSR_MEMORY_TIMEOUT: cfg_ff.memory_timeout_ms <= csr_wdata;
            msts_pkg::CSR_USB_DELAY:      cfg_ff.usb_delay_ms      <= csr_wdata;
            msts_pkg::CSR_STATUS_TIMEOUT: cfg_ff.status_timeout_ms <= csr_wdata;
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   msts_step u_step (
      .cur             (state_ff),
      .cfg             (cfg_ff),
      .kind            (kind_ff),
      .now_ms          (now_ff),
      .memory_complete (done_ff),
      .mode_ok         (mode_ff),
      .link_active     (link_ff),
      .nxt             (state_in),
      .res             (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase              <= msts_pkg::PH_IDLE;
         state_ff.memory_deadline    <= '0;
         state_ff.usb_deadline       <= '0;
         state_ff.transport_deadline <= '0;
      end else if (fire) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_start_accepted  = rsp_ff.start_accepted;
   assign rsp_enable_usb      = rsp_ff.enable_usb;
   assign rsp_fallback_native = rsp_ff.fallback_native;
   assign rsp_display_error   = rsp_ff.display_error;
   assign rsp_reset_memory    = rsp_ff.reset_memory;
   assign rsp_phase_now       = rsp_ff.phase_now;
   assign rsp_memory_busy     = rsp_ff.memory_busy;
   assign rsp_hid_busy        = rsp_ff.hid_busy;

   // the sequencer only moves when a word passes into the result register
   a_phase_holds: assert property (@(posedge clock) disable iff (reset)
      (!reset && !fire) |=> $stable(state_ff))
      else $error("sequencer state changed without a word");

   a_start_phase: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_start_accepted) |->
         (rsp_phase_now == msts_pkg::PH_MEM_START || rsp_phase_now == msts_pkg::PH_HID_DELAY))
      else $error("accepted start left sequencer in wrong phase");

   a_usb_phase: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_enable_usb) |->
         (rsp_phase_now == msts_pkg::PH_ST_WAIT || rsp_phase_now == msts_pkg::PH_HID_WAIT))
      else $error("usb enable outside a wait phase");

   a_error_phase: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_display_error) |->
         (rsp_phase_now == msts_pkg::PH_MEM_TIMEOUT && rsp_reset_memory))
      else $error("error display without memory timeout");

   a_busy_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_memory_busy && rsp_hid_busy))
      else $error("memory and hid paths both busy");

endmodule

`default_nettype wire

// ===== rtl/msts_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

module msts_step (
   input  wire msts_pkg::seq_state_type cur,
   input  wire msts_pkg::cfg_type       cfg,
   input  wire logic [1:0]              kind,
   input  wire logic [31:0]             now_ms,
   input  wire logic                    memory_complete,
   input  wire logic                    mode_ok,
   input  wire logic                    link_active,
   output msts_pkg::seq_state_type      nxt,
   output msts_pkg::result_type         res
);

   logic        link_ok;
   logic [31:0] usb_diff;
   logic [31:0] trans_diff;
   logic [31:0] mem_diff;
   logic        usb_past;
   logic        trans_past;
   logic        mem_reached;
   logic [31:0] trans_arm;
   logic        is_start;

   assign link_ok     = mode_ok & link_active;
   // wrap-safe compares: sign of the 32-bit difference
   assign usb_diff    = now_ms - cur.usb_deadline - 32'd1;
   assign trans_diff  = now_ms - cur.transport_deadline - 32'd1;
   assign mem_diff    = now_ms - cur.memory_deadline;
   assign usb_past    = ~usb_diff[31];
   assign trans_past  = ~trans_diff[31];
   assign mem_reached = ~mem_diff[31];
   assign trans_arm   = now_ms + {16'd0, cfg.status_timeout_ms};
   assign is_start    = (kind == msts_pkg::KIND_START_MEM) || (kind == msts_pkg::KIND_START_HID);

   // next state
   always_comb begin
      nxt = cur;
      if (kind == msts_pkg::KIND_STEP) begin
         case (cur.phase)
            msts_pkg::PH_MEM_START: begin
               if (memory_complete) begin
                  if (usb_past) begin
                     nxt.phase              = msts_pkg::PH_ST_WAIT;
                     nxt.transport_deadline = trans_arm;
                  end else begin
                     nxt.phase = msts_pkg::PH_ST_DELAY;
                  end
               end else if (!link_ok) begin
                  nxt.phase = msts_pkg::PH_IDLE;
               end else if (mem_reached) begin
                  nxt.phase              = msts_pkg::PH_MEM_TIMEOUT;
                  nxt.transport_deadline = trans_arm;
               end
            end
            msts_pkg::PH_ST_DELAY: begin
               if (usb_past) begin
                  nxt.phase              = msts_pkg::PH_ST_WAIT;
                  nxt.transport_deadline = trans_arm;
               end
            end
            msts_pkg::PH_HID_DELAY: begin
               if (usb_past) begin
                  nxt.phase              = msts_pkg::PH_HID_WAIT;
                  nxt.transport_deadline = trans_arm;
               end
            end
            msts_pkg::PH_ST_WAIT: begin
               if (trans_past) nxt.phase = msts_pkg::PH_ST_ACTIVE;
            end
            msts_pkg::PH_HID_WAIT: begin
               if (trans_past) nxt.phase = msts_pkg::PH_HID_ACTIVE;
            end
            msts_pkg::PH_ST_ACTIVE, msts_pkg::PH_HID_ACTIVE: begin
               if (!link_ok) nxt.phase = msts_pkg::PH_IDLE;
            end
            msts_pkg::PH_MEM_TIMEOUT: begin
               if (trans_past) nxt.phase = msts_pkg::PH_IDLE;
            end
            default: begin
               nxt = cur;
            end
         endcase
      end else if (is_start && (cur.phase == msts_pkg::PH_IDLE)) begin
         nxt.usb_deadline = now_ms + {16'd0, cfg.usb_delay_ms};
         if (kind == msts_pkg::KIND_START_MEM) begin
            nxt.memory_deadline = now_ms + {16'd0, cfg.memory_timeout_ms};
            nxt.phase           = msts_pkg::PH_MEM_START;
         end else begin
            nxt.phase = msts_pkg::PH_HID_DELAY;
         end
      end
   end

   // actions and status
   always_comb begin
      res                 = '0;
      res.start_accepted  = is_start && (cur.phase == msts_pkg::PH_IDLE);
      if (kind == msts_pkg::KIND_STEP) begin
         case (cur.phase)
            msts_pkg::PH_MEM_START: begin
               if (memory_complete) begin
                  res.enable_usb = usb_past;
               end else if (!link_ok) begin
                  res.fallback_native = 1'b1;
               end else if (mem_reached) begin
                  res.display_error = 1'b1;
                  res.reset_memory  = 1'b1;
               end
            end
            msts_pkg::PH_ST_DELAY, msts_pkg::PH_HID_DELAY: begin
               res.enable_usb = usb_past;
            end
            msts_pkg::PH_ST_ACTIVE, msts_pkg::PH_HID_ACTIVE: begin
               res.fallback_native = ~link_ok;
            end
            msts_pkg::PH_MEM_TIMEOUT: begin
               res.fallback_native = trans_past;
               res.reset_memory    = trans_past;
            end
            default: begin
               res.enable_usb = 1'b0;
            end
         endcase
      end
      res.phase_now   = nxt.phase;
      res.memory_busy = (nxt.phase == msts_pkg::PH_MEM_START) ||
                        (nxt.phase == msts_pkg::PH_MEM_TIMEOUT);
      res.hid_busy    = (nxt.phase == msts_pkg::PH_HID_DELAY) ||
                        (nxt.phase == msts_pkg::PH_HID_WAIT) ||
                        (nxt.phase == msts_pkg::PH_HID_ACTIVE);
   end

endmodule

`default_nettype wire
